// ----- hw/rtl/swm_pkg.sv -----
// shared types and constants of the sliding window median unit
`default_nettype none

package swm_pkg;

  localparam int unsigned WindowMaxDef  = 64;
  localparam int unsigned SampleBitsDef = 32;
  localparam int unsigned CfgBits       = 7;
  localparam int unsigned WindowReset   = 3;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic flush;
    logic del;
    logic ins;
  } swm_op_t;

endpackage

`default_nettype wire

// ----- hw/rtl/swm_cell.sv -----
// one cell of the sorted chain: holds one sample and shifts with its neighbours
`default_nettype none

module swm_cell #(
  parameter int unsigned SAMPLE_BITS = swm_pkg::SampleBitsDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire swm_pkg::swm_op_t        op_i,
  input  wire logic [SAMPLE_BITS-1:0]  key_i,
  input  wire logic [SAMPLE_BITS-1:0]  left_val_i,
  input  wire logic                    left_valid_i,
  input  wire logic                    left_gt_i,
  input  wire logic [SAMPLE_BITS-1:0]  right_val_i,
  input  wire logic                    right_valid_i,
  output logic [SAMPLE_BITS-1:0]       val_o,
  output logic                         valid_o,
  output logic                         gt_o
);
  import swm_pkg::*;

  logic [SAMPLE_BITS-1:0] val_q, val_d;
  logic                   valid_q, valid_d;
  logic                   ge;

  // empty cells count as larger than any key
  assign gt_o = !valid_q || ($signed(val_q) > $signed(key_i));
  assign ge   = valid_q && ($signed(val_q) >= $signed(key_i));

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (op_i.flush) begin
      valid_d = 1'b0;
    end else if (op_i.del && ge) begin
      val_d   = right_val_i;
      valid_d = right_valid_i;
    end else if (op_i.ins && gt_o) begin
      val_d   = left_gt_i ? left_val_i : key_i;
      valid_d = left_gt_i ? left_valid_i : 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ----- hw/rtl/swm_chain.sv -----
// row of sorted cells with the median tap
`default_nettype none

module swm_chain #(
  parameter int unsigned WINDOW_MAX  = swm_pkg::WindowMaxDef,
  parameter int unsigned SAMPLE_BITS = swm_pkg::SampleBitsDef,
  parameter int unsigned IW          = 6
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire swm_pkg::swm_op_t        op_i,
  input  wire logic [SAMPLE_BITS-1:0]  key_i,
  input  wire logic [IW-1:0]           mid_i,
  output logic [SAMPLE_BITS-1:0]       mid_val_o
);
  import swm_pkg::*;

  logic [SAMPLE_BITS-1:0] val   [WINDOW_MAX];
  logic                   valid [WINDOW_MAX];
  logic                   gt    [WINDOW_MAX];

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] lv, rv;
    logic                   lvalid, lgt, rvalid;

    if (i == 0) begin : g_first
      assign lv     = '0;
      assign lvalid = 1'b0;
      assign lgt    = 1'b0;
    end else begin : g_mid_l
      assign lv     = val[i-1];
      assign lvalid = valid[i-1];
      assign lgt    = gt[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign rv     = '0;
      assign rvalid = 1'b0;
    end else begin : g_mid_r
      assign rv     = val[i+1];
      assign rvalid = valid[i+1];
    end

    swm_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (op_i),
      .key_i         (key_i),
      .left_val_i    (lv),
      .left_valid_i  (lvalid),
      .left_gt_i     (lgt),
      .right_val_i   (rv),
      .right_valid_i (rvalid),
      .val_o         (val[i]),
      .valid_o       (valid[i]),
      .gt_o          (gt[i])
    );
  end

  assign mid_val_o = val[mid_i];

endmodule

`default_nettype wire

// ----- hw/rtl/sliding_window_median_unit.sv -----
// top level of the sliding window median unit
//
//  channel | valid        | flow control  | word
//  --------+--------------+---------------+------------------------
//  input   | in_valid_i   | in_stall_o    | sample_i
//  output  | out_valid_o  | out_stall_i   | median_o
//  config  | cfg_valid_i  | cfg_ready_o   | window_size_i
//
//  each sample passes accept with history read, removal pass, insertion pass and, once the
//  window is full, result write; the two shift passes run through the cell chain and new
//  samples stall until the last is done; the result write waits while the output register
//  is held by out_stall_i; a config word on offer stalls the input and is taken first
//  a config write flushes every cell of the chain together, no clearing pass after reset
`default_nettype none

module sliding_window_median_unit #(
  parameter int unsigned WINDOW_MAX  = swm_pkg::WindowMaxDef,
  parameter int unsigned SAMPLE_BITS = swm_pkg::SampleBitsDef
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0]         sample_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [SAMPLE_BITS-1:0]              median_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [swm_pkg::CfgBits-1:0]    window_size_i
);
  import swm_pkg::*;

  localparam int unsigned KW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CW = (KW > CfgBits) ? KW : CfgBits;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEL  = 2'd1;
  localparam logic [1:0] S_INS  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [KW-1:0]          k_q, k_d;
  logic [KW-1:0]          fill_q, fill_d;
  logic [IW-1:0]          ptr_q, ptr_d;
  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0] median_q;
  logic [SAMPLE_BITS-1:0] old_q, x_q;
  logic [SAMPLE_BITS-1:0] ring_q [WINDOW_MAX];

  logic                   in_acc, cfg_acc, emit;
  logic [IW-1:0]          slot;
  logic [CW-1:0]          cfg_ext;
  logic [IW-1:0]          mid;
  logic [SAMPLE_BITS-1:0] key, mid_val;
  swm_op_t                op;

  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  assign slot    = (KW'(ptr_q) >= k_q) ? '0 : ptr_q;
  assign cfg_ext = CW'(window_size_i);
  assign mid     = IW'((k_q - KW'(1)) >> 1);
  assign key     = (state_q == S_DEL) ? old_q : x_q;
  assign emit    = (state_q == S_EMIT) && (fill_q == k_q) && (!out_valid_q || !out_stall_i);

  always_comb begin
    op.flush = cfg_acc;
    op.del   = (state_q == S_DEL) && (fill_q >= k_q);
    op.ins   = (state_q == S_INS);
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (cfg_acc) begin
          if (cfg_ext == '0) begin
            k_d = KW'(1);
          end else if (cfg_ext > CW'(WINDOW_MAX)) begin
            k_d = KW'(WINDOW_MAX);
          end else begin
            k_d = KW'(cfg_ext);
          end
          fill_d = '0;
          ptr_d  = '0;
        end else if (in_acc) begin
          ptr_d   = ((KW'(slot) + KW'(1)) >= k_q) ? '0 : IW'(slot + IW'(1));
          state_d = S_DEL;
        end
      end
      S_DEL: begin
        if (op.del) begin
          fill_d = fill_q - KW'(1);
        end
        state_d = S_INS;
      end
      S_INS: begin
        fill_d  = fill_q + KW'(1);
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (fill_q != k_q) begin
          state_d = S_IDLE;
        end else if (emit) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= KW'(WindowReset);
      fill_q      <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // history ring, read of the leaving sample before it is overwritten
  always_ff @(posedge clk_i) begin
    if (in_acc && !cfg_acc) begin
      old_q        <= ring_q[slot];
      ring_q[slot] <= sample_i;
      x_q          <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      median_q <= mid_val;
    end
  end

  swm_chain #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IW          (IW)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (op),
    .key_i     (key),
    .mid_i     (mid),
    .mid_val_o (mid_val)
  );

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= k_q)
    else $error("window fill above window size");

  a_k_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q != '0)
    else $error("window size zero");

  a_del_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEL && fill_q >= k_q && !cfg_valid_i) |=> fill_q == $past(fill_q) - KW'(1))
    else $error("removal pass did not shrink the window");

  a_emit_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (fill_q == k_q && $past(state_q) == S_EMIT))
    else $error("result word without a full window");

endmodule

`default_nettype wire

// ----- tb/swm_median_checker.sv -----
// checker: tracks the median window, predicts each median word and compares the output channel
`timescale 1ns / 1ps

module swm_median_checker #(
  parameter int unsigned WINDOW_MAX  = swm_pkg::WindowMaxDef,
  parameter int unsigned SAMPLE_BITS = swm_pkg::SampleBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [SAMPLE_BITS-1:0]      sample_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [SAMPLE_BITS-1:0]      median_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [swm_pkg::CfgBits-1:0] window_size_i,
  output int unsigned                 pending_o,
  output int unsigned                 checked_o,
  output int unsigned                 errors_o
);

  logic signed [SAMPLE_BITS-1:0] history [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] ordered [WINDOW_MAX];
  int unsigned                   fill;
  int unsigned                   slot_next;
  int unsigned                   win_len;
  logic        [SAMPLE_BITS-1:0] pending_medians [$];
  int unsigned                   checked;
  int unsigned                   errors;

  task automatic advance_window(input logic signed [SAMPLE_BITS-1:0] x, output bit has_median,
                                output logic signed [SAMPLE_BITS-1:0] median);
    int unsigned slot;
    int unsigned pos;
    int unsigned i;
    bit          found;
    slot = slot_next;
    if (slot >= win_len) slot = 0;
    if (fill >= win_len) begin
      pos   = fill;
      found = 1'b0;
      for (i = 0; i < fill; i++) begin
        if (!found && ordered[i] == history[slot]) begin
          pos   = i;
          found = 1'b1;
        end
      end
      if (pos < fill) begin
        for (i = pos; i + 1 < fill; i++) ordered[i] = ordered[i+1];
        fill--;
      end
    end
    if (fill < WINDOW_MAX) begin
      i = fill;
      while (i > 0 && ordered[i-1] > x) begin
        ordered[i] = ordered[i-1];
        i--;
      end
      ordered[i] = x;
      fill++;
    end
    history[slot] = x;
    slot_next = (slot + 1 >= win_len) ? 0 : slot + 1;
    has_median = (fill >= win_len);
    median     = has_median ? ordered[(win_len + 1) / 2 - 1] : '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned                   size_w;
    logic        [SAMPLE_BITS-1:0] want;
    bit                            has_median;
    logic signed [SAMPLE_BITS-1:0] median;
    if (!rst_ni) begin
      fill      = 0;
      slot_next = 0;
      win_len   = swm_pkg::WindowReset;
      pending_medians.delete();
      checked   = 0;
      errors    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        size_w = window_size_i;
        if (size_w < 1) size_w = 1;
        if (size_w > WINDOW_MAX) size_w = WINDOW_MAX;
        win_len   = size_w;
        fill      = 0;
        slot_next = 0;
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_medians.size() == 0) begin
          $error("median: word %0d arrived with none outstanding", $signed(median_i));
          errors++;
        end else begin
          want = pending_medians.pop_front();
          if (median_i !== want) begin
            $error("median mismatch: expected %0d, actual %0d", $signed(want),
                   $signed(median_i));
            errors++;
          end
          checked++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        advance_window(sample_i, has_median, median);
        if (has_median) pending_medians.push_back(median);
      end
    end
    pending_o <= pending_medians.size();
    checked_o <= checked;
    errors_o  <= errors;
  end

endmodule

// ----- tb/tb_sliding_window_median_unit.sv -----
// testbench top: clock, reset, sample and window size stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module tb_sliding_window_median_unit;

  localparam int unsigned SampleBits = swm_pkg::SampleBitsDef;
  localparam int unsigned PhaseWords = 96;
  localparam int unsigned PhaseCount = 16;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid;
  logic                        in_stall;
  logic [SampleBits-1:0]       sample;
  logic                        out_valid;
  logic                        out_stall;
  logic [SampleBits-1:0]       median;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [swm_pkg::CfgBits-1:0] window_size;
  int unsigned                 pending;
  int unsigned                 checked;
  int unsigned                 errors;
  int unsigned                 idle_pct;
  int unsigned                 stall_pct;
  int unsigned                 words_sent;
  int unsigned                 sizes_written;

  sliding_window_median_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .sample_i     (sample),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .median_o     (median),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .window_size_i(window_size)
  );

  swm_median_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .sample_i     (sample),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .median_i     (median),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .window_size_i(window_size),
    .pending_o    (pending),
    .checked_o    (checked),
    .errors_o     (errors)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #(5_000_000);
    $display("** sliding_window_median_unit: FAILED **");
    $finish;
  end

  task automatic set_idling(input int unsigned mode);
    case (mode % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 84; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 84; end
      default: begin idle_pct = 29; stall_pct = 29; end
    endcase
  endtask

  task automatic send_sample(input logic [SampleBits-1:0] s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk_i); while (in_stall);
    words_sent++;
  endtask

  task automatic write_window(input logic [swm_pkg::CfgBits-1:0] size_w);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_valid   <= 1'b1;
    window_size <= size_w;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sizes_written++;
  endtask

  function automatic logic [SampleBits-1:0] pick_sample();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom_range(8) - 4;
      7:          return 32'h8000_0000 + $urandom_range(3);
      8:          return 32'h7fff_ffff - $urandom_range(3);
      default:    return $urandom_range(2000) - 1000;
    endcase
  endfunction

  initial begin
    logic [swm_pkg::CfgBits-1:0] sizes [PhaseCount];
    logic [SampleBits-1:0]       first_run [10];
    int unsigned                 waited;
    sizes = '{7'd1, 7'd127, 7'd64, 7'd2, 7'd65, 7'd3, 7'd0, 7'd5,
              7'd64, 7'd4, 7'd33, 7'd7, 7'd63, 7'd96, 7'd10, 7'd17};
    first_run = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                  32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h0000_0001};
    rst_ni        = 1'b0;
    in_valid      <= 1'b0;
    sample        <= '0;
    cfg_valid     <= 1'b0;
    window_size   <= '0;
    words_sent    = 0;
    sizes_written = 0;
    set_idling(0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset window of three, extremes and repeated values
    foreach (first_run[i]) send_sample(first_run[i]);
    // zero taken as one
    write_window(7'd0);
    send_sample(32'h7fff_ffff);
    send_sample(32'h8000_0000);
    send_sample(32'd5);
    // even window gives the lower of the two middle words
    write_window(7'd2);
    send_sample(32'd5);
    send_sample(32'd5);
    send_sample(-32'sd3);
    send_sample(32'h8000_0000);
    send_sample(32'h7fff_ffff);
    // oversize clamps, then flushed before it fills
    write_window(7'd65);
    repeat (4) send_sample(pick_sample());

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      write_window(sizes[p]);
      set_idling(p);
      for (int unsigned n = 0; n < PhaseWords; n++) send_sample(pick_sample());
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    waited = 0;
    while (pending != 0 && waited < 100_000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    $display("sent %0d samples over %0d window sizes, %0d medians checked, %0d left over",
             words_sent, sizes_written + 1, checked, pending);
    if (errors == 0 && pending == 0) begin
      $display("** sliding_window_median_unit: PASSED **");
    end else begin
      $display("** sliding_window_median_unit: FAILED **");
    end
    $finish;
  end

endmodule
